// ===== src/mdf_pkg.sv =====
// Package: constants, stage type and exponent for the Fermat modular divider.
package mdf_pkg;

    localparam longint unsigned MODULUS = 64'd1000000007;
    // Residue width; the prime is assumed below 2^30.
    localparam int MW = 30;
    // Fermat exponent for the inverse.
    localparam logic [MW-1:0] EXP = MW'(MODULUS - 64'd2);
    // 2^32 mod p, used to fold the upper word of a 64-bit input.
    localparam logic [MW-1:0] FOLD_C = MW'(64'h1_0000_0000 % MODULUS);
    // Barrett reduction: y < 2^63, t = y >> 29, q ~ (t * R) >> 34.
    localparam int YW = 63;
    localparam int TSH = 29;
    localparam int TW = YW - TSH;
    localparam int RW = 34;
    localparam logic [RW-1:0] BARRETT_R = RW'(64'h8000_0000_0000_0000 / MODULUS);
    localparam logic [31:0] P32 = 32'(MODULUS);
    localparam logic [31:0] P2X = 32'(MODULUS * 64'd2);
    // Cycles through one reduction and one modular multiply.
    localparam int RED_LAT = 4;
    localparam int MM_LAT = RED_LAT + 1;

    typedef struct packed {
        logic          vld;
        logic [MW-1:0] acc;
        logic [MW-1:0] base;
        logic [MW-1:0] num;
        logic          dz;
    } stage_t;

endpackage

// ===== src/mdf_reduce.sv =====
// Four-stage Barrett reduction of a 63-bit value modulo the prime.
module mdf_reduce (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [mdf_pkg::YW-1:0]  y,
    output logic [mdf_pkg::MW-1:0]  r
);
    logic [mdf_pkg::YW-1:0]              y1_reg;
    logic [mdf_pkg::TW+mdf_pkg::RW-1:0]  m1_reg;
    logic [mdf_pkg::RW-1:0]              q;
    logic [63:0]                         qp;
    logic [31:0]                         r2_reg, r3_reg, r4_reg;

    assign q  = m1_reg[mdf_pkg::TW+mdf_pkg::RW-1 -: mdf_pkg::RW];
    assign qp = 64'(q) * 64'(mdf_pkg::P32);

    always_ff @(posedge aclk) begin
        if (en) begin
            y1_reg <= y;
            m1_reg <= (mdf_pkg::TW+mdf_pkg::RW)'(y[mdf_pkg::YW-1:mdf_pkg::TSH])
                    * (mdf_pkg::TW+mdf_pkg::RW)'(mdf_pkg::BARRETT_R);
            // estimate is short by at most two, so the remainder stays below 3p
            r2_reg <= y1_reg[31:0] - qp[31:0];
            r3_reg <= (r2_reg >= mdf_pkg::P2X) ? r2_reg - mdf_pkg::P2X : r2_reg;
            r4_reg <= (r3_reg >= mdf_pkg::P32) ? r3_reg - mdf_pkg::P32 : r3_reg;
        end
    end

    assign r = r4_reg[mdf_pkg::MW-1:0];
endmodule

// ===== src/mdf_mulmod.sv =====
// Pipelined modular multiplier: product register followed by Barrett reduction.
module mdf_mulmod (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [mdf_pkg::MW-1:0] a,
    input  logic [mdf_pkg::MW-1:0] b,
    output logic [mdf_pkg::MW-1:0] r
);
    logic [2*mdf_pkg::MW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (2*mdf_pkg::MW)'(a) * (2*mdf_pkg::MW)'(b);
        end
    end

    mdf_reduce u_reduce (
        .aclk (aclk),
        .en   (en),
        .y    (mdf_pkg::YW'(prod_reg)),
        .r    (r)
    );
endmodule

// ===== src/mdf_cell.sv =====
// One square-and-multiply cell: handles one exponent bit for the item passing through.
module mdf_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  exp_bit,
    input  mdf_pkg::stage_t       in_s,
    output mdf_pkg::stage_t       out_s
);
    mdf_pkg::stage_t          dly_reg [mdf_pkg::MM_LAT];
    logic [mdf_pkg::MW-1:0]   sq, pr;

    mdf_mulmod u_square (.aclk(aclk), .en(en), .a(in_s.base), .b(in_s.base), .r(sq));
    mdf_mulmod u_mult   (.aclk(aclk), .en(en), .a(in_s.acc),  .b(in_s.base), .r(pr));

    // hold the item's other fields alongside the multipliers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mdf_pkg::MM_LAT; i++) begin
                dly_reg[i].vld <= 1'b0;
            end
        end else if (en) begin
            dly_reg[0] <= in_s;
            for (int i = 1; i < mdf_pkg::MM_LAT; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    always_comb begin
        out_s      = dly_reg[mdf_pkg::MM_LAT-1];
        out_s.base = sq;
        out_s.acc  = exp_bit ? pr : dly_reg[mdf_pkg::MM_LAT-1].acc;
    end
endmodule

// ===== src/modular_division_fermat.sv =====
// Top level: division modulo a fixed prime through a chain of square-and-multiply cells.
// Path: input fold register and Barrett reduction, 30 square-and-multiply cells, the final
// multiply and the output register. Throughput: one item per cycle while not stalled;
// every cell holds five items in its multiplier stages.
// Backpressure freezes the whole chain once the skid register behind the output fills.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset.
module modular_division_fermat (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] numerator, [127:64] denominator
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [29:0] quotient, [31:30] zero
    output logic [0:0]   m_tuser    // [0] div_by_zero
);
    localparam int MW = mdf_pkg::MW;

    logic en;
    logic skid_vld_reg;

    // ---- input reduction: fold the upper word, then Barrett ----
    logic [mdf_pkg::YW-1:0] fold_num_reg, fold_den_reg;
    logic                   in_vld_reg [mdf_pkg::MM_LAT];
    logic [MW-1:0]          num_r, den_r;

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_num_reg <= mdf_pkg::YW'(s_tdata[63:32]) * mdf_pkg::YW'(mdf_pkg::FOLD_C)
                          + mdf_pkg::YW'(s_tdata[31:0]);
            fold_den_reg <= mdf_pkg::YW'(s_tdata[127:96]) * mdf_pkg::YW'(mdf_pkg::FOLD_C)
                          + mdf_pkg::YW'(s_tdata[95:64]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mdf_pkg::MM_LAT; i++) begin
                in_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            in_vld_reg[0] <= s_tvalid;
            for (int i = 1; i < mdf_pkg::MM_LAT; i++) begin
                in_vld_reg[i] <= in_vld_reg[i-1];
            end
        end
    end

    mdf_reduce u_red_num (.aclk(aclk), .en(en), .y(fold_num_reg), .r(num_r));
    mdf_reduce u_red_den (.aclk(aclk), .en(en), .y(fold_den_reg), .r(den_r));

    // ---- exponent chain: one cell per bit of p-2, LSB first ----
    mdf_pkg::stage_t chain [MW+1];

    always_comb begin
        chain[0].vld  = in_vld_reg[mdf_pkg::MM_LAT-1];
        chain[0].acc  = MW'(1);
        chain[0].base = den_r;
        chain[0].num  = num_r;
        chain[0].dz   = (den_r == '0);
    end

    for (genvar g = 0; g < MW; g++) begin : g_cell
        mdf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .exp_bit (mdf_pkg::EXP[g]),
            .in_s    (chain[g]),
            .out_s   (chain[g+1])
        );
    end

    // ---- final multiply by the numerator ----
    logic [MW-1:0]   qv;
    mdf_pkg::stage_t fin_reg [mdf_pkg::MM_LAT];

    mdf_mulmod u_final (.aclk(aclk), .en(en), .a(chain[MW].acc), .b(chain[MW].num), .r(qv));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mdf_pkg::MM_LAT; i++) begin
                fin_reg[i].vld <= 1'b0;
            end
        end else if (en) begin
            fin_reg[0] <= chain[MW];
            for (int i = 1; i < mdf_pkg::MM_LAT; i++) begin
                fin_reg[i] <= fin_reg[i-1];
            end
        end
    end

    logic          fin_vld, fin_dz;
    logic [MW-1:0] fin_q;

    assign fin_vld = fin_reg[mdf_pkg::MM_LAT-1].vld;
    assign fin_dz  = fin_reg[mdf_pkg::MM_LAT-1].dz;
    // a zero denominator drives the power, and so the product, to zero already
    assign fin_q   = fin_dz ? '0 : qv;

    // ---- output register with skid: the chain advances while the skid is empty ----
    logic          out_vld_reg;
    logic [MW-1:0] out_q_reg, skid_q_reg;
    logic          out_dz_reg, skid_dz_reg;

    assign en = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            // drain the skid into the output once the item ahead is taken
            if (m_tready) begin
                out_q_reg    <= skid_q_reg;
                out_dz_reg   <= skid_dz_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_tready) begin
            out_vld_reg <= fin_vld;
            out_q_reg   <= fin_q;
            out_dz_reg  <= fin_dz;
        end else if (fin_vld) begin
            skid_q_reg   <= fin_q;
            skid_dz_reg  <= fin_dz;
            skid_vld_reg <= 1'b1;
        end
    end

    assign s_tready   = !skid_vld_reg;
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = 32'(out_q_reg);
    assign m_tuser[0] = out_dz_reg;

`ifndef SYNTHESIS
    // a held skid item always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while output is empty");

    // a zero denominator yields a zero quotient
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("div_by_zero with nonzero quotient");

    // quotient stays a residue
    a_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (64'(m_tdata) < mdf_pkg::MODULUS))
        else $error("quotient not reduced");

    // the skid only fills when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid filled without a stall");
`endif
endmodule
